### hw/rtl/hist_eq_pkg.sv
package hist_eq_pkg;

    localparam int GRAY_LEVELS = 256;
    localparam int IMAGE_SIDE  = 256;

    localparam int PIX_W   = 8;
    localparam int PC_W    = 21;
    localparam int BIN_W   = 21;
    localparam int LEVEL_W = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
    localparam int CUM_W   = BIN_W + LEVEL_W;
    localparam int QUO_W   = PIX_W + 1;
    localparam int NUM_W   = CUM_W + PIX_W;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam logic [BIN_W-1:0] BIN_MAX  = {BIN_W{1'b1}};
    localparam logic [PIX_W-1:0] MAP_MAX  = {PIX_W{1'b1}};
    localparam logic [PC_W-1:0]  PC_RESET = PC_W'(IMAGE_SIDE * IMAGE_SIDE);
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(GRAY_LEVELS - 1);

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_MAP   = 1'b1;

    typedef struct packed {
        logic count_accept;
        logic map_accept;
        logic bins_clear;
        logic bin_update;
        logic build_init;
        logic bin_read;
        logic cum_add;
        logic div_load;
        logic div_step;
        logic map_write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic idx_last;
    } dp_status_t;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [PIX_W-1:0] pix);
        logic [PIX_W:0] top;
        top = (PIX_W+1)'(GRAY_LEVELS - 1);
        if ({1'b0, pix} > top)
            return LEVEL_TOP;
        else
            return pix[LEVEL_W-1:0];
    endfunction

endpackage

### hw/rtl/histogram_equalizer.sv
// Map pixel: one word per cycle while idle, busy stays low; result strobes the next cycle.
// Count pixel: bin read, then bin write, busy high for one cycle.
// Last count pixel: the table build follows, one gray level at a time: read, accumulate,
// load, then the 9-step shift-subtract divider and write; busy stays high throughout.
// Reset: bins and table read as zero, pixel_count is 65536; results cannot be stalled.
module histogram_equalizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [hist_eq_pkg::PIX_W-1:0]  pixel,
    input  logic                           last_pixel,
    output logic                           out_valid,
    output logic [hist_eq_pkg::PIX_W-1:0]  out_pixel,
    output logic                           end_of_image,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hist_eq_pkg::PC_W-1:0]   cfg_data
);

    import hist_eq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = ~busy;

    hist_eq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .last_pixel (last_pixel),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    hist_eq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_pixel    (out_pixel),
        .end_of_image (end_of_image)
    );

endmodule

### hw/rtl/hist_eq_ram.sv
module hist_eq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/hist_eq_ctrl.sv
module hist_eq_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    req_type,
    input  logic                    last_pixel,
    input  hist_eq_pkg::dp_status_t status,
    output hist_eq_pkg::ctrl_cmd_t  cmd,
    output logic                    busy
);

    import hist_eq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CNT_WR  = 3'd1;
    localparam logic [2:0] S_BLD_RD  = 3'd2;
    localparam logic [2:0] S_BLD_ACC = 3'd3;
    localparam logic [2:0] S_BLD_MUL = 3'd4;
    localparam logic [2:0] S_BLD_DIV = 3'd5;
    localparam logic [2:0] S_BLD_WR  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       last_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_MAP)
                    begin
                        cmd.map_accept = 1'b1;
                        cmd.bins_clear = last_pixel;
                    end
                    else
                    begin
                        cmd.count_accept = 1'b1;
                        state_next       = S_CNT_WR;
                    end
                end
            end
            S_CNT_WR:
            begin
                cmd.bin_update = 1'b1;
                if (last_reg)
                begin
                    cmd.build_init = 1'b1;
                    state_next     = S_BLD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BLD_RD:
            begin
                cmd.bin_read = 1'b1;
                state_next   = S_BLD_ACC;
            end
            S_BLD_ACC:
            begin
                cmd.cum_add = 1'b1;
                state_next  = S_BLD_MUL;
            end
            S_BLD_MUL:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_BLD_DIV;
            end
            S_BLD_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_BLD_WR;
                end
            end
            S_BLD_WR:
            begin
                cmd.map_write = 1'b1;
                state_next    = status.idx_last ? S_IDLE : S_BLD_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.count_accept)
            begin
                last_reg <= last_pixel;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### hw/rtl/hist_eq_dp.sv
module hist_eq_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hist_eq_pkg::ctrl_cmd_t             cmd,
    output hist_eq_pkg::dp_status_t            status,
    input  logic [hist_eq_pkg::PIX_W-1:0]      pixel,
    input  logic                               last_pixel,
    input  logic                               cfg_we,
    input  logic [hist_eq_pkg::PC_W-1:0]       cfg_data,
    output logic                               out_valid,
    output logic [hist_eq_pkg::PIX_W-1:0]      out_pixel,
    output logic                               end_of_image
);

    import hist_eq_pkg::*;

    logic [LEVEL_W-1:0]     level_in;
    logic [LEVEL_W-1:0]     level_reg;
    logic [GRAY_LEVELS-1:0] bin_valid_reg;
    logic [LEVEL_W-1:0]     bin_raddr;
    logic [BIN_W-1:0]       bin_rdata;
    logic [BIN_W-1:0]       bin_cur;
    logic [BIN_W-1:0]       bin_wdata;
    logic [BIN_W-1:0]       bin_sel;
    logic [LEVEL_W-1:0]     idx_reg;
    logic [CUM_W-1:0]       cum_reg;
    logic [NUM_W-1:0]       rem_reg;
    logic [NUM_W-1:0]       rem_next;
    logic [NUM_W-1:0]       dvs_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   quo_bit;
    logic [PC_W-1:0]        pixel_count_reg;
    logic [PC_W-1:0]        divisor;
    logic [PIX_W-1:0]       map_wdata;
    logic [PIX_W-1:0]       map_rdata;
    logic                   built_reg;
    logic                   out_valid_reg;
    logic                   eoi_reg;

    assign level_in  = level_of(pixel);
    assign bin_raddr = cmd.bin_read ? idx_reg : level_in;
    assign bin_cur   = bin_valid_reg[level_reg] ? bin_rdata : '0;
    assign bin_wdata = (bin_cur == BIN_MAX) ? bin_cur : bin_cur + BIN_W'(1);
    assign bin_sel   = bin_valid_reg[idx_reg] ? bin_rdata : '0;
    assign divisor   = (pixel_count_reg == '0) ? PC_W'(1) : pixel_count_reg;
    assign quo_bit   = (rem_reg >= dvs_reg);
    assign rem_next  = quo_bit ? rem_reg - dvs_reg : rem_reg;
    assign map_wdata = quo_reg[QUO_W-1] ? MAP_MAX : quo_reg[PIX_W-1:0];

    assign status.div_done = (step_reg == '0);
    assign status.idx_last = (idx_reg == LEVEL_TOP);

    hist_eq_ram #(
        .WIDTH (BIN_W),
        .DEPTH (GRAY_LEVELS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (cmd.bin_update),
        .waddr (level_reg),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    hist_eq_ram #(
        .WIDTH (PIX_W),
        .DEPTH (GRAY_LEVELS)
    ) u_map_ram (
        .clk   (clk),
        .we    (cmd.map_write),
        .waddr (idx_reg),
        .wdata (map_wdata),
        .raddr (level_in),
        .rdata (map_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg   <= '0;
            built_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            eoi_reg         <= 1'b0;
            pixel_count_reg <= PC_RESET;
        end
        else
        begin
            if (cmd.bins_clear)
            begin
                bin_valid_reg <= '0;
            end
            else if (cmd.bin_update)
            begin
                bin_valid_reg[level_reg] <= 1'b1;
            end
            if (cmd.map_write)
            begin
                built_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                pixel_count_reg <= cfg_data;
            end
            out_valid_reg <= cmd.map_accept;
            eoi_reg       <= cmd.map_accept & last_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.count_accept)
        begin
            level_reg <= level_in;
        end
        if (cmd.build_init)
        begin
            idx_reg <= '0;
            cum_reg <= '0;
        end
        else
        begin
            if (cmd.map_write)
            begin
                idx_reg <= idx_reg + LEVEL_W'(1);
            end
            if (cmd.cum_add)
            begin
                cum_reg <= cum_reg + CUM_W'(bin_sel);
            end
        end
        if (cmd.div_load)
        begin
            rem_reg  <= {cum_reg, {PIX_W{1'b0}}} - NUM_W'(cum_reg);
            dvs_reg  <= NUM_W'({divisor, {PIX_W{1'b0}}});
            step_reg <= STEP_W'(QUO_W - 1);
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
            quo_reg  <= {quo_reg[QUO_W-2:0], quo_bit};
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = built_reg ? map_rdata : '0;
    assign end_of_image = eoi_reg;

endmodule

### hw/rtl/hist_eq_checker.sv
module hist_eq_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic req_type,
    input logic last_pixel,
    input logic out_valid,
    input logic end_of_image
);

    import hist_eq_pkg::*;

    a_result_follows_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(start && !busy && (req_type == REQ_MAP)))
        else $error("result word without a map word");

    a_map_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_MAP))
            |=> (out_valid && !busy && (end_of_image == $past(last_pixel))))
        else $error("map word lost or end flag wrong");

    a_eoi_only_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_image |-> out_valid)
        else $error("end of image without result");

    a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_COUNT)) |=> (busy && !out_valid))
        else $error("count word did not hold busy");

    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_COUNT) && last_pixel) |=> busy ##1 busy)
        else $error("table build did not hold busy");

endmodule

bind histogram_equalizer hist_eq_checker u_checker (.*);

### sim/tb_histogram_equalizer.sv
module tb_histogram_equalizer;
    timeunit 1ns;
    timeprecision 1ps;

    import hist_eq_pkg::*;

    localparam int BUILD_WAIT = GRAY_LEVELS * 13 + 32;
    localparam int WORD_TARGET = 1150;
    localparam logic [PC_W-1:0] PC_TOP = {PC_W{1'b1}};

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [PC_W-1:0]  size;
        logic             rt;
        logic [PIX_W-1:0] pix;
        logic             lst;
        logic             typed;
        logic [PIX_W-1:0] level;
        logic             eoi;
    } plan_row_t;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             eoi;
    } eq_word_t;

    localparam plan_row_t PLAN [27] = '{
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd0,   1'b1},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd170, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd85,  1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd0,   1'b1},
        '{ROW_CFG,  PC_W'(1), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd128, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b1},
        '{ROW_CFG,  PC_W'(0), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd64,  1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd63,  1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd64,  1'b0, 1'b1, 8'd255, 1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b1},
        '{ROW_CFG,  PC_TOP,   REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_CFG,  PC_W'(2), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_COUNT, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd127, 1'b0},
        '{ROW_WORD, PC_W'(0), REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b1}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic req_type;
    logic [PIX_W-1:0] pixel;
    logic last_pixel;
    logic out_valid;
    logic [PIX_W-1:0] out_pixel;
    logic end_of_image;
    logic cfg_valid;
    logic cfg_ready;
    logic [PC_W-1:0] cfg_data;

    logic [BIN_W-1:0] bin_tally [GRAY_LEVELS];
    logic [PIX_W-1:0] level_table [GRAY_LEVELS];
    logic [PC_W-1:0] image_size;
    eq_word_t levels_due [$];
    int mismatches = 0;
    int words_sent = 0;

    histogram_equalizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .pixel        (pixel),
        .last_pixel   (last_pixel),
        .out_valid    (out_valid),
        .out_pixel    (out_pixel),
        .end_of_image (end_of_image),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic rebuild_table();
        longint unsigned cum;
        longint unsigned quo;
        longint unsigned dv;
        cum = 0;
        dv = (image_size == '0) ? 1 : image_size;
        for (int v = 0; v < GRAY_LEVELS; v++)
        begin
            cum += bin_tally[v];
            quo = (cum * 255) / dv;
            level_table[v] = (quo > 255) ? MAP_MAX : quo[PIX_W-1:0];
        end
    endtask

    task automatic account_word(input logic rt, input logic [PIX_W-1:0] pix,
                                input logic lst, output bit emits, output eq_word_t w);
        int idx;
        idx = (pix > GRAY_LEVELS - 1) ? GRAY_LEVELS - 1 : int'(pix);
        emits = 1'b0;
        w = '0;
        if (rt == REQ_COUNT)
        begin
            if (bin_tally[idx] != BIN_MAX)
                bin_tally[idx]++;
            if (lst)
                rebuild_table();
        end
        else
        begin
            emits = 1'b1;
            w.level = level_table[idx];
            w.eoi = lst;
            if (lst)
                foreach (bin_tally[k])
                    bin_tally[k] = '0;
        end
    endtask

    task automatic push_word(input logic rt, input logic [PIX_W-1:0] pix, input logic lst,
                             input logic typed, input logic [PIX_W-1:0] level,
                             input logic eoi);
        bit emits;
        eq_word_t w;
        if (!(words_sent >= 400 && words_sent < 600) && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        pixel <= pix;
        last_pixel <= lst;
        do @(negedge clk); while (busy);
        @(posedge clk);
        account_word(rt, pix, lst, emits, w);
        if (typed)
        begin
            w.level = level;
            w.eoi = eoi;
        end
        if (emits)
            levels_due.push_back(w);
        words_sent++;
    endtask

    // hold off until the block is drained, including any table build in flight
    task automatic write_size(input logic [PC_W-1:0] value);
        start <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk);
        repeat (BUILD_WAIT) @(posedge clk);
        repeat ($urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        image_size = value;
    endtask

    function automatic logic [PIX_W-1:0] pick_level(input int centre, input int spread);
        int v;
        if ($urandom_range(2) == 0)
            return PIX_W'($urandom_range(255));
        v = centre + $urandom_range(spread);
        return (v > 255) ? MAP_MAX : PIX_W'(v);
    endfunction

    task automatic run_pass(input logic rt, input int n, input int centre, input int spread);
        for (int i = 0; i < n; i++)
            push_word(rt, pick_level(centre, spread), i == n - 1, 1'b0, '0, 1'b0);
    endtask

    always @(negedge clk)
    begin
        eq_word_t w;
        if (rst_n === 1'b1 && out_valid === 1'b1)
        begin
            if (levels_due.size() == 0)
            begin
                $error("unexpected word: out_pixel %0d end_of_image %0d",
                       out_pixel, end_of_image);
                mismatches++;
            end
            else
            begin
                w = levels_due.pop_front();
                if (out_pixel !== w.level)
                begin
                    $error("out_pixel: expected %0d, got %0d", w.level, out_pixel);
                    mismatches++;
                end
                if (end_of_image !== w.eoi)
                begin
                    $error("end_of_image: expected %0d, got %0d", w.eoi, end_of_image);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [PC_W-1:0] sz;
        int shape;
        int n;
        int m;
        int centre;
        int spread;

        foreach (bin_tally[k])
        begin
            bin_tally[k] = '0;
            level_table[k] = '0;
        end
        image_size = PC_RESET;
        rst_n <= 1'b0;
        start <= 1'b0;
        req_type <= REQ_COUNT;
        pixel <= '0;
        last_pixel <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
                write_size(PLAN[i].size);
            else
                push_word(PLAN[i].rt, PLAN[i].pix, PLAN[i].lst,
                          PLAN[i].typed, PLAN[i].level, PLAN[i].eoi);
        end

        while (words_sent < WORD_TARGET)
        begin
            case ($urandom_range(9))
                0: sz = '0;
                1: sz = PC_W'(1);
                2: sz = PC_TOP;
                3: sz = PC_W'(1048576);
                4: sz = PC_RESET;
                5: sz = PC_W'($urandom);
                default: sz = PC_W'($urandom_range(1, 64));
            endcase
            write_size(sz);
            repeat ($urandom_range(1, 4))
            begin
                shape = $urandom_range(99);
                n = ($urandom_range(9) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
                m = $urandom_range(1, 48);
                centre = $urandom_range(255);
                spread = $urandom_range(1, 80);
                if (shape < 80)
                begin
                    run_pass(REQ_COUNT, n, centre, spread);
                    run_pass(REQ_MAP, m, centre, spread);
                end
                else if (shape < 88)
                    run_pass(REQ_COUNT, n, centre, spread);
                else if (shape < 94)
                    run_pass(REQ_MAP, m, centre, spread);
                else
                    repeat ($urandom_range(1, 10))
                        push_word(1'($urandom_range(1)), PIX_W'($urandom_range(255)),
                                  1'($urandom_range(1)), 1'b0, '0, 1'b0);
            end
        end

        start <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk);
        repeat (BUILD_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
